@@ rtl/vpcf_pkg.sv @@
// ----------------------------------------------------------------------------
// vpcf_pkg
// Shared types and constants for the voice prompt command framer.
// ----------------------------------------------------------------------------
package vpcf_pkg;

    localparam int VPCF_QUEUE_DEPTH = 8;

    localparam int PROMPT_W = 16;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 3;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // frame bytes of a play-file command
    localparam logic [BYTE_W-1:0] FRAME_START  = 8'h7E;
    localparam logic [BYTE_W-1:0] FRAME_COUNT  = 8'h04;
    localparam logic [BYTE_W-1:0] FRAME_SELECT = 8'h03;
    localparam logic [BYTE_W-1:0] FRAME_TERM   = 8'hEF;

    // frame positions
    localparam logic [POS_W-1:0] POS_START    = 3'd0;
    localparam logic [POS_W-1:0] POS_COUNT    = 3'd1;
    localparam logic [POS_W-1:0] POS_SELECT   = 3'd2;
    localparam logic [POS_W-1:0] POS_FILE_HI  = 3'd3;
    localparam logic [POS_W-1:0] POS_FILE_LO  = 3'd4;
    localparam logic [POS_W-1:0] POS_LAST     = 3'd5;
    localparam logic [POS_W-1:0] POS_WAIT     = 3'd6;

    // register index of quiet_mode
    localparam logic REG_QUIET_MODE = 1'b0;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_CHECK = 2'd1,
        ACT_READY = 2'd2
    } action_t;

    typedef struct packed {
        logic [1:0]          action;
        logic [PROMPT_W-1:0] prompt;
        logic                busy_req;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              frame_end;
    } out_item_t;

endpackage

@@ rtl/vpcf_ram.sv @@
// ----------------------------------------------------------------------------
// vpcf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module vpcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/voice_prompt_command_framer.sv @@
// ----------------------------------------------------------------------------
// voice_prompt_command_framer
// Queues voice prompts and sends each as a six-byte play-file frame.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_stall/in_data) carries events: push a prompt,
//   periodic check tick with the module busy line, or transmitter ready.
//   output channel (out_valid/out_stall/out_data) carries frame bytes for the
//   serial transmitter; frame_end marks the termination byte.
//   a check tick on a non-empty queue, while not busy and not waiting, pops a
//   prompt and sends the start byte; each transmitter ready sends the next.
//   quiet_mode is written over the apb port at byte address 0.
// timing:
//   one event per cycle while in_stall is low; a frame byte appears in the
//   output register in the cycle after the event transfer. the queue ram read
//   port is used once per frame, at the pop.
// reset:
//   queue empty, framer idle, quiet mode off; queue entries are not cleared.
// stall:
//   while the output register holds a byte and out_stall is high, in_stall
//   is raised and no event is taken.
// ----------------------------------------------------------------------------
module voice_prompt_command_framer
    import vpcf_pkg::*;
#(
    parameter int QUEUE_DEPTH = VPCF_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             sending_reg, sending_next;
    logic             quiet_reg;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg;

    logic             accept;
    logic             push_en;
    logic             pop_en;
    logic             result;
    out_item_t        result_data;
    logic [POS_W-1:0] pos_inc;
    logic [PROMPT_W-1:0] file_word;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign pos_inc  = pos_reg + POS_W'(1);

    always_comb
    begin
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        sending_next = sending_reg;
        push_en      = 1'b0;
        pop_en       = 1'b0;
        result       = 1'b0;
        result_data  = '{tx_byte: FRAME_START, frame_end: 1'b0};
        if (accept)
        begin
            unique case (in_data.action)
                ACT_PUSH:
                begin
                    if (!quiet_reg && (count_reg < CNT_W'(QUEUE_DEPTH)))
                    begin
                        push_en     = 1'b1;
                        wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                      '0 : wr_ptr_reg + PTR_W'(1);
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                ACT_CHECK:
                begin
                    // ticks during a frame or on an empty queue do nothing
                    if (!sending_reg && (count_reg != '0))
                    begin
                        if (in_data.busy_req)
                        begin
                            pos_next = POS_WAIT;
                        end
                        else if (pos_reg == POS_WAIT)
                        begin
                            pos_next = POS_START;
                        end
                        else
                        begin
                            pop_en       = 1'b1;
                            rd_ptr_next  = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                           '0 : rd_ptr_reg + PTR_W'(1);
                            count_next   = count_reg - CNT_W'(1);
                            pos_next     = POS_START;
                            sending_next = 1'b1;
                            result       = 1'b1;
                        end
                    end
                end
                ACT_READY:
                begin
                    if (sending_reg)
                    begin
                        if (pos_reg >= POS_LAST)
                        begin
                            sending_next = 1'b0;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                            result   = 1'b1;
                            unique case (pos_inc)
                                POS_COUNT:   result_data.tx_byte = FRAME_COUNT;
                                POS_SELECT:  result_data.tx_byte = FRAME_SELECT;
                                POS_FILE_HI: result_data.tx_byte = file_word[15:8];
                                POS_FILE_LO: result_data.tx_byte = file_word[7:0];
                                default:     result_data.tx_byte = FRAME_TERM;
                            endcase
                            if (pos_inc == POS_LAST)
                            begin
                                result_data.frame_end = 1'b1;
                                sending_next          = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // the ram read register doubles as the current file until the next pop
    vpcf_ram #(
        .WIDTH (PROMPT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (push_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (in_data.prompt + PROMPT_W'(1)),
        .rd_en   (pop_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (file_word)
    );

    always_comb
    begin
        if (result)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            pos_reg       <= POS_START;
            sending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            sending_reg   <= sending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result)
        begin
            out_data_reg <= result_data;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_QUIET_MODE))
        begin
            quiet_reg <= pwdata[0];
        end
    end

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_QUIET_MODE) ? {{(DATA_W-1){1'b0}}, quiet_reg} : '0;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/vpcf_checker.sv @@
// ----------------------------------------------------------------------------
// vpcf_checker
// Port-level checks for the voice prompt command framer.
// ----------------------------------------------------------------------------
module vpcf_checker
    import vpcf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // a held byte stays put until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output byte changed while stalled");

    // events are only held off by a stalled output byte
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled output");

    // the termination flag only goes with the termination byte
    a_term_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_end |-> out_data.tx_byte == FRAME_TERM)
        else $error("frame_end on a byte other than the termination byte");

    // a push never yields a byte in the next cycle
    a_push_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.action == ACT_PUSH) && !out_valid
        |=> !out_valid)
        else $error("byte produced by a push");

endmodule

bind voice_prompt_command_framer vpcf_checker u_vpcf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the voice prompt command framer against a cycle-free model of its
// queue and frame sequencer. A short scripted part covers the extremes and
// corner cases, then random event streams run under several quiet settings.
// The input idles and the output stalls at random; every frame byte is compared.
// ----------------------------------------------------------------------------
module testbench;
    import vpcf_pkg::*;

    localparam int           DEPTH       = VPCF_QUEUE_DEPTH;
    localparam int           DIR_ROWS    = 28;
    localparam int           HOLD_CYCLES = 60;
    localparam int           IDLE_LIMIT  = 2000;
    localparam int           MAX_LINES   = 100;
    localparam logic [1:0]   ACT_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]          act;
        logic [PROMPT_W-1:0] prompt;
        logic                busy;
        logic                typed;
        logic                want;
        out_item_t           result;
    } script_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    in_item_t          in_data;
    logic              out_valid;
    logic              out_stall;
    out_item_t         out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // framer model state
    logic [PROMPT_W-1:0] file_queue [DEPTH];
    int unsigned         rd_slot;
    int unsigned         wr_slot;
    int unsigned         queued;
    logic [POS_W-1:0]    frame_pos;
    bit                  sending;
    logic [PROMPT_W-1:0] file_now;
    bit                  quiet_now;

    out_item_t   pending_bytes [$];
    script_row_t script [DIR_ROWS];
    int          errors;
    bit          calm;
    bit          hold_req;

    voice_prompt_command_framer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_LINES)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // applies one accepted event to the model
    task automatic advance_framer(input in_item_t ev, output bit got, output out_item_t b);
        got    = 1'b0;
        b      = '0;
        case (ev.action)
            ACT_PUSH:
            begin
                if (!quiet_now && queued < DEPTH)
                begin
                    file_queue[wr_slot] = ev.prompt + 1'b1;
                    wr_slot = (wr_slot + 1) % DEPTH;
                    queued++;
                end
            end
            ACT_CHECK:
            begin
                if (!sending && queued != 0)
                begin
                    if (ev.busy_req)
                        frame_pos = POS_WAIT;
                    else if (frame_pos == POS_WAIT)
                        frame_pos = POS_START;
                    else
                    begin
                        file_now  = file_queue[rd_slot];
                        rd_slot   = (rd_slot + 1) % DEPTH;
                        queued--;
                        frame_pos = POS_START;
                        sending   = 1'b1;
                        got       = 1'b1;
                        b.tx_byte = FRAME_START;
                    end
                end
            end
            ACT_READY:
            begin
                if (sending)
                begin
                    if (frame_pos >= POS_LAST)
                        sending = 1'b0;
                    else
                    begin
                        frame_pos = frame_pos + 1'b1;
                        got = 1'b1;
                        case (frame_pos)
                            POS_COUNT:   b.tx_byte = FRAME_COUNT;
                            POS_SELECT:  b.tx_byte = FRAME_SELECT;
                            POS_FILE_HI: b.tx_byte = file_now[15:8];
                            POS_FILE_LO: b.tx_byte = file_now[7:0];
                            default:     b.tx_byte = FRAME_TERM;
                        endcase
                        b.frame_end = (frame_pos == POS_LAST);
                        if (frame_pos == POS_LAST)
                            sending = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic script_row_t script_row(input logic [1:0] act,
                                               input logic [PROMPT_W-1:0] prompt,
                                               input logic busy, input logic typed,
                                               input logic want,
                                               input logic [BYTE_W-1:0] tx,
                                               input logic fin);
        script_row_t s;
        s.act              = act;
        s.prompt           = prompt;
        s.busy             = busy;
        s.typed            = typed;
        s.want             = want;
        s.result.tx_byte   = tx;
        s.result.frame_end = fin;
        return s;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_event(input in_item_t ev, input int gap,
                              output bit got, output out_item_t b);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do
            @(posedge clk);
        while (in_stall);
        advance_framer(ev, got, b);
        @(negedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(4 * int'(REG_QUIET_MODE));
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        if (wr)
            quiet_now = wdata[0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // drain the framer, let it settle, then change quiet mode and read it back
    task automatic set_quiet(input bit q);
        logic [DATA_W-1:0] rd;
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        apb_access(1'b1, DATA_W'(q), rd);
        @(negedge clk);
        apb_access(1'b0, '0, rd);
        if (rd !== DATA_W'(quiet_now))
            report_mismatch($sformatf("quiet_mode read %0h", rd));
    endtask

    // receiver side: random stalls plus one long hold on request
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
            end
            else if (stall_left == 0 && !calm)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    stall_left = $urandom_range(1, 3);
                else if (r < 22)
                    stall_left = $urandom_range(10, 30);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h", out_data.tx_byte));
            else
            begin
                want = pending_bytes.pop_front();
                if (out_data.tx_byte !== want.tx_byte)
                    report_mismatch($sformatf("tx_byte %02h, expected %02h",
                                              out_data.tx_byte, want.tx_byte));
                if (out_data.frame_end !== want.frame_end)
                    report_mismatch($sformatf("frame_end %b, expected %b",
                                              out_data.frame_end, want.frame_end));
            end
        end
    end

    // watchdog: cycles in a row with no transfer on any port
    always @(posedge clk)
    begin
        int idle_cycles;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (psel && penable))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        in_item_t  ev;
        out_item_t b;
        bit        got;
        int        r;
        int        n;
        int        target;
        int        push_pct;
        bit        q;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        errors   = 0;
        calm     = 1'b0;
        hold_req = 1'b0;
        rd_slot   = 0;
        wr_slot   = 0;
        queued    = 0;
        frame_pos = POS_START;
        sending   = 1'b0;
        file_now  = '0;
        quiet_now = 1'b0;

        script[0]  = script_row(ACT_READY,  16'h0000, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        script[1]  = script_row(ACT_CHECK,  16'h0000, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        script[2]  = script_row(ACT_UNUSED, 16'hFFFF, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        script[3]  = script_row(ACT_PUSH,   16'hFFFF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        script[4]  = script_row(ACT_PUSH,   16'h0000, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        script[5]  = script_row(ACT_PUSH,   16'h5555, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        script[6]  = script_row(ACT_PUSH,   16'hAAAA, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        script[7]  = script_row(ACT_PUSH,   16'h8000, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        script[8]  = script_row(ACT_PUSH,   16'h7FFF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        script[9]  = script_row(ACT_PUSH,   16'h00FF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        script[10] = script_row(ACT_PUSH,   16'hFF00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        // queue full, dropped
        script[11] = script_row(ACT_PUSH,   16'h1234, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        // busy sets the wait mark, next quiet tick only clears it
        script[12] = script_row(ACT_CHECK,  16'h0000, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        script[13] = script_row(ACT_CHECK,  16'h0000, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        // first file is 0xffff + 1, wrapped to zero
        script[14] = script_row(ACT_CHECK,  16'h0000, 1'b0, 1'b1, 1'b1, FRAME_START, 1'b0);
        script[15] = script_row(ACT_READY,  16'h0000, 1'b0, 1'b1, 1'b1, FRAME_COUNT, 1'b0);
        script[16] = script_row(ACT_READY,  16'h0000, 1'b0, 1'b1, 1'b1, FRAME_SELECT, 1'b0);
        script[17] = script_row(ACT_READY,  16'h0000, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
        // tick in the middle of a frame is ignored
        script[18] = script_row(ACT_CHECK,  16'h0000, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        script[19] = script_row(ACT_READY,  16'h0000, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
        script[20] = script_row(ACT_READY,  16'h0000, 1'b0, 1'b1, 1'b1, FRAME_TERM, 1'b1);
        script[21] = script_row(ACT_READY,  16'h0000, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        script[22] = script_row(ACT_CHECK,  16'h0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        for (int i = 23; i < DIR_ROWS; i++)
            script[i] = script_row(ACT_READY, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_quiet(1'b0);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            ev.action   = script[i].act;
            ev.prompt   = script[i].prompt;
            ev.busy_req = script[i].busy;
            send_event(ev, pick_gap(), got, b);
            if (script[i].typed)
            begin
                if (script[i].want)
                    pending_bytes.push_back(script[i].result);
            end
            else if (got)
                pending_bytes.push_back(b);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin q = 1'b0; push_pct = 30; target = 200; end
                1: begin q = 1'b1; push_pct = 50; target = 50;  end
                2: begin q = 1'b0; push_pct = 15; target = 160; end
                3: begin q = 1'b1; push_pct = 40; target = 40;  end
                default: begin q = 1'b0; push_pct = 45; target = 220; end
            endcase
            calm = 1'b0;
            set_quiet(q);
            // no idling, and the receiver holds off so the input backs up
            if (ph == 2)
            begin
                calm     = 1'b1;
                hold_req = 1'b1;
            end
            n = 0;
            while (n < target)
            begin
                r = $urandom_range(0, 99);
                ev.prompt   = PROMPT_W'($urandom);
                ev.busy_req = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 15) == 0)
                    ev.prompt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                if (r < push_pct)
                    ev.action = ACT_PUSH;
                else if (r >= 96)
                    ev.action = ACT_UNUSED;
                else if (r < push_pct + (96 - push_pct) / 3)
                    ev.action = ACT_CHECK;
                else
                    ev.action = ACT_READY;
                send_event(ev, pick_gap(), got, b);
                if (got)
                    pending_bytes.push_back(b);
                n++;
            end
        end

        calm = 1'b0;
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
